/* sv/ctsc_pkg.sv */
// shared types and constants for the two-step composition counter
package ctsc_pkg;

	localparam int LEN_W  = 16;
	localparam int WAY_W  = 30;
	localparam int SUM_W  = 32;
	localparam int MAX_LEN = 65535;
	localparam int DEPTH  = MAX_LEN + 1;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [WAY_W-1:0] PRIME_MOD = WAY_W'(1000000007);
	localparam logic [SUM_W-1:0] PRIME_2X  = SUM_W'(2000000014);

	// source of one block term at the summing stage
	localparam logic [1:0] TERM_NONE = 2'd0;
	localparam logic [1:0] TERM_BASE = 2'd1;
	localparam logic [1:0] TERM_MEM  = 2'd2;
	localparam logic [1:0] TERM_FWD  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture a new request word
		logic issue;    // walk one table entry
		logic load_out; // move the finished count to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;     // entry zero is being issued
	} sts_t;

endpackage

/* sv/ctsc_ctrl.sv */
// controller state machine for the composition counter
module ctsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ctsc_pkg::sts_t sts,
	output ctsc_pkg::cmd_t cmd
);
	import ctsc_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				cmd.issue = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// checks
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && sts.last) |=> (state_q == S_DRAIN))
		else $error("walk did not drain after entry zero");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output word overwritten before taken");
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_RUN))
		else $error("accepted word did not start a walk");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result lost");

endmodule

/* sv/ctsc_dp.sv */
// datapath: table memory, two-stage walk with forwarding and modular sum
module ctsc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ctsc_pkg::cmd_t                  cmd,
	output ctsc_pkg::sts_t                  sts,
	input  logic [ctsc_pkg::LEN_W-1:0]      min_length,
	input  logic [ctsc_pkg::LEN_W-1:0]      max_length,
	input  logic [ctsc_pkg::LEN_W-1:0]      first_block_length,
	input  logic [ctsc_pkg::LEN_W-1:0]      second_block_length,
	output logic [ctsc_pkg::WAY_W-1:0]      way_count
);
	import ctsc_pkg::*;

	logic [WAY_W-1:0]  mem [DEPTH];

	logic [LEN_W-1:0]  lo_q, top_q, blk_a_q, blk_b_q;
	logic [ADDR_W-1:0] pos_q;

	logic [LEN_W:0]    next_a, next_b;
	logic              base;
	logic [1:0]        sel_a, sel_b;

	logic              v_s1;
	logic [ADDR_W-1:0] pos_s1;
	logic              base_s1;
	logic [1:0]        sel_a_s1, sel_b_s1;
	logic [WAY_W-1:0]  rd_a_s1, rd_b_s1, fwd_s1;

	logic [WAY_W-1:0]  term_a, term_b;
	logic [SUM_W-1:0]  sum;
	logic [WAY_W-1:0]  wdata;
	logic [WAY_W-1:0]  res_q, out_q;

	assign sts.last  = (pos_q == '0);
	assign way_count = out_q;

	// stage 0: addresses and term selection for the entry being issued
	assign next_a = {1'b0, pos_q} + {1'b0, blk_a_q};
	assign next_b = {1'b0, pos_q} + {1'b0, blk_b_q};
	assign base   = (pos_q >= lo_q);

	always_comb begin
		if (blk_a_q == '0) begin
			sel_a = TERM_BASE;
		end else if (next_a > {1'b0, top_q}) begin
			sel_a = TERM_NONE;
		end else if (v_s1 && next_a[ADDR_W-1:0] == pos_s1) begin
			sel_a = TERM_FWD;
		end else begin
			sel_a = TERM_MEM;
		end
		if (blk_b_q == '0) begin
			sel_b = TERM_BASE;
		end else if (next_b > {1'b0, top_q}) begin
			sel_b = TERM_NONE;
		end else if (v_s1 && next_b[ADDR_W-1:0] == pos_s1) begin
			sel_b = TERM_FWD;
		end else begin
			sel_b = TERM_MEM;
		end
	end

	// request capture and walk position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q    <= min_length;
			top_q   <= max_length;
			blk_a_q <= first_block_length;
			blk_b_q <= second_block_length;
			pos_q   <= max_length;
		end else if (cmd.issue) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		pos_s1   <= pos_q;
		base_s1  <= base;
		sel_a_s1 <= sel_a;
		sel_b_s1 <= sel_b;
		fwd_s1   <= wdata;
	end

	// table memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem[pos_s1] <= wdata;
		end
		rd_a_s1 <= mem[next_a[ADDR_W-1:0]];
		rd_b_s1 <= mem[next_b[ADDR_W-1:0]];
	end

	// stage 1: pick terms, add and reduce
	always_comb begin
		case (sel_a_s1)
			TERM_BASE: term_a = WAY_W'(base_s1);
			TERM_MEM:  term_a = rd_a_s1;
			TERM_FWD:  term_a = fwd_s1;
			default:   term_a = '0;
		endcase
		case (sel_b_s1)
			TERM_BASE: term_b = WAY_W'(base_s1);
			TERM_MEM:  term_b = rd_b_s1;
			TERM_FWD:  term_b = fwd_s1;
			default:   term_b = '0;
		endcase
	end

	assign sum = SUM_W'(base_s1) + SUM_W'(term_a) + SUM_W'(term_b);

	always_comb begin
		if (sum >= PRIME_2X) begin
			wdata = WAY_W'(sum - PRIME_2X);
		end else if (sum >= SUM_W'(PRIME_MOD)) begin
			wdata = WAY_W'(sum - SUM_W'(PRIME_MOD));
		end else begin
			wdata = sum[WAY_W-1:0];
		end
	end

	// result capture and output register
	always_ff @(posedge clk) begin
		if (v_s1 && pos_s1 == '0) begin
			res_q <= wdata;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

endmodule

/* sv/count_two_step_compositions_mod.sv */
// top level of the two-step composition counter
//
// channel  handshake              word
// in       in_valid / in_ready    min_length, max_length, first/second_block_length
// out      out_valid / out_ready  way_count
//
// the result word becomes valid once its request is accepted and the walk is done: one
// table entry is walked per cycle, limited by the single write port of the table memory,
// then the sum stage drains and the output register is loaded once it is free.
// one request is in flight at a time; the next is taken in the cycle after the result
// moves to the output register.
// reset clears control only; the table is scratch and needs no clearing.
// a stalled output lets the next walk finish, then holds its count and the input closed.
module count_two_step_compositions_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ctsc_pkg::LEN_W-1:0] min_length,
	input  logic [ctsc_pkg::LEN_W-1:0] max_length,
	input  logic [ctsc_pkg::LEN_W-1:0] first_block_length,
	input  logic [ctsc_pkg::LEN_W-1:0] second_block_length,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ctsc_pkg::WAY_W-1:0] way_count
);
	import ctsc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller
	ctsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	ctsc_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.min_length          (min_length),
		.max_length          (max_length),
		.first_block_length  (first_block_length),
		.second_block_length (second_block_length),
		.way_count           (way_count)
	);

endmodule
